>>> rtl/spa_pkg.sv
// Shared types and constants for the serial panel register access block.
package spa_pkg;

  // command selector codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  // frame header bytes
  localparam logic [7:0] CMD_INDEX = 8'h70;
  localparam logic [7:0] CMD_WRITE = 8'h72;
  localparam logic [7:0] CMD_READ  = 8'h73;

  // index of the last bit in a frame
  localparam logic [4:0] LAST_BIT = 5'd23;

  localparam int FRAME_W = 24;

  // one tick of input
  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] reg_index;
    logic [15:0] write_data;
    logic        miso_bit;
  } tick_in_t;

  // one tick of result
  typedef struct packed {
    logic                sck;
    logic                mosi;
    logic                select_n;
    logic                busy_res;
    logic                done_res;
    logic [FRAME_W-1:0]  read_frame;
    logic                rejected;
  } tick_out_t;

endpackage

>>> rtl/spa_core.sv
// Sequencer state and per-tick next-state logic for the serial access.
module spa_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  spa_pkg::tick_in_t tick_in,
  output spa_pkg::tick_out_t tick_out
);

  logic        active, active_next;
  logic        is_read, is_read_next;
  logic        frame_number, frame_number_next;
  logic [4:0]  bit_count, bit_count_next;
  logic        half_bit, half_bit_next;
  logic [23:0] out_shift, out_shift_next;
  logic [23:0] in_shift, in_shift_next;
  logic [15:0] held_data, held_data_next;
  logic        clock_level, clock_level_next;
  logic        select_level, select_level_next;

  logic cmd;

  assign cmd = (tick_in.func == spa_pkg::FUNC_READ) || (tick_in.func == spa_pkg::FUNC_WRITE);

  // compute one tick of the sequencer
  always_comb begin
    active_next       = active;
    is_read_next      = is_read;
    frame_number_next = frame_number;
    bit_count_next    = bit_count;
    half_bit_next     = half_bit;
    out_shift_next    = out_shift;
    in_shift_next     = in_shift;
    held_data_next    = held_data;
    clock_level_next  = clock_level;
    select_level_next = select_level;

    tick_out            = '0;
    tick_out.rejected   = active && cmd;

    // start an access when idle
    if (!active && cmd) begin
      active_next       = 1'b1;
      is_read_next      = (tick_in.func == spa_pkg::FUNC_READ);
      frame_number_next = 1'b0;
      bit_count_next    = '0;
      half_bit_next     = 1'b0;
      held_data_next    = tick_in.write_data;
      out_shift_next    = {spa_pkg::CMD_INDEX, tick_in.reg_index};
      in_shift_next     = '0;
    end

    // run one half bit
    if (active_next) begin
      tick_out.mosi = out_shift_next[23];
      if (!half_bit_next) begin
        clock_level_next  = 1'b0;
        select_level_next = 1'b0;
        half_bit_next     = 1'b1;
      end else begin
        in_shift_next    = {in_shift_next[22:0], tick_in.miso_bit};
        out_shift_next   = {out_shift_next[22:0], 1'b0};
        clock_level_next = 1'b1;
        half_bit_next    = 1'b0;
        if (bit_count_next >= spa_pkg::LAST_BIT) begin
          select_level_next = 1'b1;
          bit_count_next    = '0;
          if (!frame_number_next) begin
            frame_number_next = 1'b1;
            out_shift_next    = is_read_next ? {spa_pkg::CMD_READ, 16'h0000}
                                             : {spa_pkg::CMD_WRITE, held_data_next};
            in_shift_next     = '0;
          end else begin
            frame_number_next   = 1'b0;
            active_next         = 1'b0;
            tick_out.done_res   = 1'b1;
            tick_out.read_frame = is_read_next ? in_shift_next : '0;
          end
        end else begin
          bit_count_next = bit_count_next + 5'd1;
        end
      end
    end

    tick_out.sck      = clock_level_next;
    tick_out.select_n = select_level_next;
    tick_out.busy_res = active_next;
  end

  // advance state on each tick
  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      is_read      <= 1'b0;
      frame_number <= 1'b0;
      bit_count    <= '0;
      half_bit     <= 1'b0;
      out_shift    <= '0;
      in_shift     <= '0;
      held_data    <= '0;
      clock_level  <= 1'b1;
      select_level <= 1'b1;
    end else if (step) begin
      active       <= active_next;
      is_read      <= is_read_next;
      frame_number <= frame_number_next;
      bit_count    <= bit_count_next;
      half_bit     <= half_bit_next;
      out_shift    <= out_shift_next;
      in_shift     <= in_shift_next;
      held_data    <= held_data_next;
      clock_level  <= clock_level_next;
      select_level <= select_level_next;
    end
  end

  // select is only driven low inside an access
  a_select_busy: assert property (@(posedge clk) disable iff (rst)
    !select_level |-> active)
    else $error("select low while idle");

  // bit counter never runs past the last bit
  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= spa_pkg::LAST_BIT)
    else $error("bit counter out of range");

  // the start tick runs the first half of bit 0 of the first frame
  a_start_frame: assert property (@(posedge clk) disable iff (rst)
    $rose(active) |-> !frame_number && half_bit && (bit_count == 5'd0))
    else $error("access started mid frame");

endmodule

>>> rtl/spi_panel_register_access.sv
// Top level: input and result registers around the serial access sequencer.
// Path: a tick's input transfer is captured in the input register, stepped through the
// sequencer and captured in the result register when the result slot is free.
// Throughput: one tick per cycle unless m_tready stalls; the input register, the
// single-pass step logic and the result register each take one tick per cycle.
// Reset (rst, synchronous): sequencer idle, serial clock and select high,
// both stream stages empty.
module spi_panel_register_access (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // reg_index[15:0], write_data[31:16], miso_bit[32], zeros
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // sck[0], mosi[1], select_n[2], busy_res[3],
                                 // read_frame[27:4], rejected[28], zeros
  output logic        m_tlast    // done_res
);

  logic               in_valid;
  spa_pkg::tick_in_t  in_reg;
  logic               step;
  spa_pkg::tick_out_t step_out;
  spa_pkg::tick_out_t out_reg;

  // step when an input is held and the result slot is free
  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  // hold one input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_reg.func       <= s_tuser;
      in_reg.reg_index  <= s_tdata[15:0];
      in_reg.write_data <= s_tdata[31:16];
      in_reg.miso_bit   <= s_tdata[32];
    end
  end

  spa_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .tick_in  (in_reg),
    .tick_out (step_out)
  );

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_reg <= step_out;
    end
  end

  assign m_tdata = {3'b000, out_reg.rejected, out_reg.read_frame, out_reg.busy_res,
                    out_reg.select_n, out_reg.mosi, out_reg.sck};
  assign m_tlast = out_reg.done_res;

  // a finished access is never still busy
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tdata[3])
    else $error("done while busy");

  // captured frame only shows with done
  a_frame_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[27:4] != 24'h0) |-> m_tlast)
    else $error("read frame without done");

  // serial clock is only low during an access
  a_sck_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[3])
    else $error("clock low while idle");

endmodule

>>> verif/spi_panel_register_access_checker.sv
// Checker for the serial panel register access block: predicts each tick and compares.
`timescale 1ns / 100ps

module spi_panel_register_access_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // reg_index[15:0], write_data[31:16], miso_bit[32], zeros
  input  logic [1:0]  s_tuser,   // func[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // sck[0], mosi[1], select_n[2], busy_res[3],
                                 // read_frame[27:4], rejected[28], zeros
  input  logic        m_tlast,   // done_res
  output int          fail_count,
  output int          pending
);

  // predicted sequencer state
  logic        seq_active;
  logic        seq_read;
  logic        seq_frame2;
  logic [4:0]  seq_bits;
  logic        seq_half;
  logic [23:0] tx_shift;
  logic [23:0] rx_shift;
  logic [15:0] wr_hold;
  logic        sck_lvl;
  logic        sel_lvl;

  spa_pkg::tick_out_t owed_ticks[$];
  int                 bad_cnt = 0;

  // Advance the predicted sequencer by one tick and return the pins after it.
  function automatic spa_pkg::tick_out_t step_sequencer(spa_pkg::tick_in_t t);
    spa_pkg::tick_out_t r;
    logic               is_cmd;
    is_cmd = (t.func == spa_pkg::FUNC_READ) || (t.func == spa_pkg::FUNC_WRITE);
    r = '0;
    if (seq_active) begin
      r.rejected = is_cmd;
    end else if (is_cmd) begin
      seq_active = 1'b1;
      seq_read   = (t.func == spa_pkg::FUNC_READ);
      seq_frame2 = 1'b0;
      seq_bits   = '0;
      seq_half   = 1'b0;
      wr_hold    = t.write_data;
      tx_shift   = {spa_pkg::CMD_INDEX, t.reg_index};
      rx_shift   = '0;
    end
    if (seq_active) begin
      r.mosi = tx_shift[23];
      if (!seq_half) begin
        // clock low phase: drive the bit
        sck_lvl  = 1'b0;
        sel_lvl  = 1'b0;
        seq_half = 1'b1;
      end else begin
        // clock high phase: sample and shift
        rx_shift = {rx_shift[22:0], t.miso_bit};
        tx_shift = {tx_shift[22:0], 1'b0};
        sck_lvl  = 1'b1;
        seq_half = 1'b0;
        if (seq_bits >= spa_pkg::LAST_BIT) begin
          sel_lvl  = 1'b1;
          seq_bits = '0;
          if (!seq_frame2) begin
            seq_frame2 = 1'b1;
            tx_shift   = seq_read ? {spa_pkg::CMD_READ, 16'h0000}
                                  : {spa_pkg::CMD_WRITE, wr_hold};
            rx_shift   = '0;
          end else begin
            seq_frame2   = 1'b0;
            seq_active   = 1'b0;
            r.done_res   = 1'b1;
            r.read_frame = seq_read ? rx_shift : '0;
          end
        end else begin
          seq_bits = seq_bits + 5'd1;
        end
      end
    end
    r.sck      = sck_lvl;
    r.select_n = sel_lvl;
    r.busy_res = seq_active;
    return r;
  endfunction

  // Check result transfers first, then predict the tick accepted at this edge.
  always @(posedge clk) begin : watch
    spa_pkg::tick_in_t  cur_in;
    spa_pkg::tick_out_t want;
    spa_pkg::tick_out_t got;
    if (rst) begin
      seq_active = 1'b0;
      seq_read   = 1'b0;
      seq_frame2 = 1'b0;
      seq_bits   = '0;
      seq_half   = 1'b0;
      tx_shift   = '0;
      rx_shift   = '0;
      wr_hold    = '0;
      sck_lvl    = 1'b1;
      sel_lvl    = 1'b1;
      owed_ticks.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.sck        = m_tdata[0];
        got.mosi       = m_tdata[1];
        got.select_n   = m_tdata[2];
        got.busy_res   = m_tdata[3];
        got.read_frame = m_tdata[27:4];
        got.rejected   = m_tdata[28];
        got.done_res   = m_tlast;
        if (owed_ticks.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("unexpected result transfer: tdata %h tlast %b", m_tdata, m_tlast);
        end else begin
          want = owed_ticks.pop_front();
          if (got !== want) begin
            bad_cnt++;
            if (bad_cnt <= 10)
              $display("mismatch: expected sck %b mosi %b sel_n %b busy %b done %b ",
                       want.sck, want.mosi, want.select_n, want.busy_res, want.done_res,
                       "frame %h rej %b, ", want.read_frame, want.rejected,
                       "got sck %b mosi %b sel_n %b busy %b done %b ",
                       got.sck, got.mosi, got.select_n, got.busy_res, got.done_res,
                       "frame %h rej %b", got.read_frame, got.rejected);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        cur_in.func       = s_tuser;
        cur_in.reg_index  = s_tdata[15:0];
        cur_in.write_data = s_tdata[31:16];
        cur_in.miso_bit   = s_tdata[32];
        owed_ticks.push_back(step_sequencer(cur_in));
      end
    end
    pending    <= owed_ticks.size();
    fail_count <= bad_cnt;
  end

endmodule

>>> verif/spi_panel_register_access_test.sv
// Testbench top: drives ticks and read/write accesses into the block and gives the verdict.
`timescale 1ns / 100ps

module spi_panel_register_access_test;

  // selector value with no meaning; behaves as a plain tick
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 200;
  localparam int TICK_TARGET  = 1950;
  localparam int FRAME_TICKS  = 96;

  // miso patterns for one access
  typedef enum logic [1:0] {
    MISO_RANDOM, MISO_ZEROS, MISO_ONES, MISO_TOGGLE
  } miso_kind_e;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // reg_index[15:0], write_data[31:16], miso_bit[32], zeros
  logic [1:0]  s_tuser = spa_pkg::FUNC_TICK;   // func[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // sck[0], mosi[1], select_n[2], busy_res[3],
                               // read_frame[27:4], rejected[28], zeros
  logic        m_tlast;        // done_res

  int   fail_count;
  int   pending_count;
  int   sent_ticks = 0;
  int   idle_cycles = 0;
  logic steady = 1'b0;
  logic hold_req = 1'b0;

  spi_panel_register_access i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  spi_panel_register_access_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // End the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** spi_panel_register_access: FAILED **");
      $finish;
    end
  end

  // Drive result ready: random stalls, plus one long hold-off when asked.
  initial begin : result_side
    int   run;
    int   gap;
    logic held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      run = $urandom_range(1, 40);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      case ($urandom_range(0, 9))
        0, 1, 2:       gap = 0;
        3, 4, 5, 6, 7: gap = $urandom_range(1, 3);
        8:             gap = $urandom_range(4, 10);
        default:       gap = $urandom_range(20, 60);
      endcase
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Offer one tick after an optional gap and hold it until the transfer.
  task automatic send_tick(input logic [1:0] f, input logic [15:0] ri,
                           input logic [15:0] wd, input logic mb);
    int gap;
    int r;
    gap = 0;
    if (!steady) begin
      r = $urandom_range(0, 99);
      if (r >= 95)
        gap = $urandom_range(10, 40);
      else if (r >= 70)
        gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, mb, wd, ri};
    s_tuser  <= f;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_ticks++;
  endtask

  // Run one full two-frame access; with edge_cmds, poke commands at the frame edges.
  task automatic run_access(input logic [1:0] f, input logic [15:0] ri, input logic [15:0] wd,
                            input miso_kind_e mk, input int noise_pct, input logic edge_cmds);
    logic [1:0] fsel;
    logic       mb;
    steady = ($urandom_range(0, 3) == 0);
    for (int t = 0; t < FRAME_TICKS; t++) begin
      case (mk)
        MISO_ZEROS:  mb = 1'b0;
        MISO_ONES:   mb = 1'b1;
        MISO_TOGGLE: mb = t[1];
        default:     mb = 1'($urandom_range(0, 1));
      endcase
      fsel = spa_pkg::FUNC_TICK;
      if (t == 0)
        fsel = f;
      else if (edge_cmds && (t == 1 || t == 95))
        fsel = spa_pkg::FUNC_READ;
      else if (edge_cmds && t == 47)
        fsel = spa_pkg::FUNC_WRITE;
      else if (edge_cmds && t == 2)
        fsel = FUNC_SPARE;
      else if ($urandom_range(0, 99) < noise_pct)
        fsel = 2'($urandom_range(0, 3));
      if (t == 0)
        send_tick(fsel, ri, wd, mb);
      else
        send_tick(fsel, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), mb);
    end
    steady = 1'b0;
  endtask

  initial begin : stimulus
    int r;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: idle ticks, field extremes, rejects at frame edges, back-to-back accesses
    send_tick(spa_pkg::FUNC_TICK, 16'hFFFF, 16'hFFFF, 1'b1);
    send_tick(FUNC_SPARE, 16'hFFFF, 16'hFFFF, 1'b1);
    send_tick(spa_pkg::FUNC_TICK, 16'h0000, 16'h0000, 1'b0);
    run_access(spa_pkg::FUNC_WRITE, 16'hFFFF, 16'h0000, MISO_ZEROS, 0, 1'b1);
    run_access(spa_pkg::FUNC_READ, 16'h0000, 16'hFFFF, MISO_ONES, 0, 1'b0);
    run_access(spa_pkg::FUNC_READ, 16'hA5C3, 16'h5A3C, MISO_TOGGLE, 0, 1'b1);
    run_access(spa_pkg::FUNC_WRITE, 16'h0000, 16'hFFFF, MISO_RANDOM, 0, 1'b0);
    send_tick(FUNC_SPARE, 16'h0000, 16'h0000, 1'b0);

    // random: mostly whole accesses with noise, some loose ticks
    hold_req = 1'b1;
    while (sent_ticks < TICK_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        repeat ($urandom_range(0, 4))
          send_tick($urandom_range(0, 1) ? spa_pkg::FUNC_TICK : FUNC_SPARE,
                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1)));
        run_access($urandom_range(0, 1) ? spa_pkg::FUNC_READ : spa_pkg::FUNC_WRITE,
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   miso_kind_e'($urandom_range(0, 3)),
                   $urandom_range(0, 1) ? 0 : $urandom_range(1, 8), 1'b0);
      end else begin
        repeat ($urandom_range(1, 8))
          send_tick(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      end
    end
    s_tvalid <= 1'b0;

    // drain, then allow for the pipeline latency
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("** spi_panel_register_access: PASSED **");
    else
      $display("** spi_panel_register_access: FAILED **");
    $finish;
  end

endmodule
